[rtl/register_vm_execute_unit_core_defines.svh]
// Assertion macros shared by the RTL files.
`ifndef REGISTER_VM_EXECUTE_UNIT_CORE_DEFINES_SVH
`define REGISTER_VM_EXECUTE_UNIT_CORE_DEFINES_SVH

// Asserts that the antecedent implies the consequent in the same cycle.
`define RVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Asserts that the antecedent implies the consequent in the next cycle.
`define RVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/rvm_pkg.sv]
`default_nettype none
package rvm_pkg;
  localparam int unsigned NumRegs    = 16;
  localparam int unsigned StackDepth = 256;
  localparam int unsigned RegIdxW    = $clog2(NumRegs);
  localparam int unsigned StackIdxW  = $clog2(StackDepth);
  localparam int unsigned CountW     = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    OpNoop = 4'd0, OpMove = 4'd1, OpXchg = 4'd2, OpPush = 4'd3, OpPop = 4'd4,
    OpAdd = 4'd5, OpSub = 4'd6, OpMul = 4'd7, OpDiv = 4'd8, OpNeg = 4'd9,
    OpAnd = 4'd10, OpOr = 4'd11, OpNot = 4'd12, OpRes13 = 4'd13,
    OpRes14 = 4'd14, OpRes15 = 4'd15
  } opcode_e;

  typedef enum logic [1:0] {
    StOk = 2'd0, StOverflow = 2'd1, StUnderflow = 2'd2, StDivZero = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [3:0]         dest_index;
    logic signed [31:0] src_operand;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] dest_value;
    logic [8:0]         stack_depth;
  } rsp_t;
endpackage
`default_nettype wire

[rtl/rvm_ram.sv]
`default_nettype none
module rvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic      [Width-1:0]         rdata_a_o,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

[rtl/rvm_muldiv.sv]
`default_nettype none
`include "register_vm_execute_unit_core_defines.svh"
module rvm_muldiv (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        div_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic             done_o,
  output logic [31:0]      res_o
);
  import rvm_pkg::*;

  logic        busy_q, busy_d, div_q, div_d, neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] acc_q, acc_d, rem_q, rem_d, b_q, b_d, a_q, a_d;
  logic [32:0] trial;
  logic [31:0] rem_sh, ma, mb;

  assign ma = a_i[31] ? 32'(-a_i) : a_i;
  assign mb = b_i[31] ? 32'(-b_i) : b_i;
  assign rem_sh = {rem_q[30:0], a_q[31]};
  assign trial = {1'b0, rem_sh} - {1'b0, b_q};

  always_comb begin
    busy_d = busy_q;
    div_d = div_q;
    neg_d = neg_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    rem_d = rem_q;
    b_d = b_q;
    a_d = a_q;
    done_o = 1'b0;
    res_o = neg_q ? 32'(-acc_q) : acc_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      div_d = div_i;
      neg_d = div_i && (a_i[31] != b_i[31]);
      cnt_d = 6'd0;
      acc_d = '0;
      rem_d = '0;
      a_d = div_i ? ma : a_i;
      b_d = div_i ? mb : b_i;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) begin
        busy_d = 1'b0;
        done_o = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
        a_d = {a_q[30:0], 1'b0};
        if (div_q) begin
          if (!trial[32]) begin
            rem_d = trial[31:0];
            acc_d = {acc_q[30:0], 1'b1};
          end else begin
            rem_d = rem_sh;
            acc_d = {acc_q[30:0], 1'b0};
          end
        end else begin
          acc_d = {acc_q[30:0], 1'b0} + (a_q[31] ? b_q : 32'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  `RVM_ASSERT_IMP(a_done_busy, clk_i, rst_ni, done_o, busy_q)
  `RVM_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, busy_q, cnt_q <= 6'd32)
  `RVM_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_q)
endmodule
`default_nettype wire

[rtl/register_vm_execute_unit_core.sv]
// Register machine execute unit.
// Input: one instruction transaction is taken when start_i is high and busy_o
// is low; the payload is req_i (opcode, destination index, source operand).
// Output: one result transaction per instruction, shown on rsp_o for exactly
// one cycle while done_o is high; the receiver cannot stall it.
// Registers live in a 16-entry RAM, the value stack in a 256-entry RAM, both
// with registered reads. An instruction reads its two registers in the
// cycle after start and is written back in the next cycle. Push also writes
// the stack; pop reads it and writes the register in state SPop, and an
// exchange of two distinct registers writes its second register in state
// SWr2. Multiply and divide run in a shift-add / restoring unit of 32 steps.
// busy_o is high from acceptance until the result cycle, so one instruction
// is in flight at a time.
// Reset clears the stack count. The register file is cleared by a sweep over
// all 16 registers after reset, during which busy_o is high.
// Failing push, pop or divide leaves all state unchanged and reports status.
`default_nettype none
`include "register_vm_execute_unit_core_defines.svh"
module register_vm_execute_unit_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rvm_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output rvm_pkg::rsp_t      rsp_o
);
  import rvm_pkg::*;

  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SRead = 3'd2, SExec = 3'd3,
                         SMd = 3'd4, SPop = 3'd5, SWr2 = 3'd6;

  logic [2:0]         state_q, state_d;
  logic [RegIdxW-1:0] clr_q, clr_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [3:0]         op_q;
  logic [RegIdxW-1:0] d_q, s_q;
  logic [31:0]        imm_q, dv_q;
  logic               done_q, done_d;
  rsp_t               rsp_q, rsp_d;

  logic               rf_we;
  logic [RegIdxW-1:0] rf_wa;
  logic [31:0]        rf_wd, rf_ra, rf_rb;
  logic               st_we;
  logic [StackIdxW-1:0] st_wa, st_ra;
  logic [31:0]        st_rd, st_unused;
  logic               md_start, md_done;
  logic [31:0]        md_res, dv, sv, res;
  logic               accept;

  assign accept = start_i && (state_q == SIdle);
  assign busy_o = (state_q != SIdle);
  assign done_o = done_q;
  assign rsp_o = rsp_q;

  rvm_ram #(.Width(32), .Depth(NumRegs)) u_rf (
    .clk_i, .we_i(rf_we), .waddr_i(rf_wa), .wdata_i(rf_wd),
    .raddr_a_i(d_q), .rdata_a_o(rf_ra),
    .raddr_b_i(s_q), .rdata_b_o(rf_rb)
  );

  rvm_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(dv),
    .raddr_a_i(st_ra), .rdata_a_o(st_rd),
    .raddr_b_i(st_ra), .rdata_b_o(st_unused)
  );

  rvm_muldiv u_md (
    .clk_i, .rst_ni, .start_i(md_start), .div_i(op_q == OpDiv),
    .a_i(dv), .b_i(sv), .done_o(md_done), .res_o(md_res)
  );

  assign dv = rf_ra;
  assign sv = (s_q == d_q) ? rf_ra : rf_rb;
  assign st_wa = cnt_q[StackIdxW-1:0];
  assign st_ra = StackIdxW'(cnt_q - CountW'(1));

  always_comb begin
    res = dv;
    case (op_q)
      OpMove: res = imm_q;
      OpXchg: res = sv;
      OpAdd: res = dv + sv;
      OpSub: res = dv - sv;
      OpNeg: res = 32'(-dv);
      OpAnd: res = {31'd0, (dv != 0) && (sv != 0)};
      OpOr: res = {31'd0, (dv != 0) || (sv != 0)};
      OpNot: res = {31'd0, dv == 0};
      default: res = dv;
    endcase
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cnt_d = cnt_q;
    done_d = 1'b0;
    rsp_d = rsp_q;
    rf_we = 1'b0;
    rf_wa = d_q;
    rf_wd = res;
    st_we = 1'b0;
    md_start = 1'b0;
    unique case (state_q)
      SClr: begin
        rf_we = 1'b1;
        rf_wa = clr_q;
        rf_wd = '0;
        clr_d = clr_q + RegIdxW'(1);
        if (clr_q == RegIdxW'(NumRegs - 1)) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (accept) begin
          state_d = SRead;
        end
      end
      SRead: begin
        state_d = SExec;
      end
      SExec: begin
        rsp_d.status = StOk;
        rsp_d.dest_value = dv;
        rsp_d.stack_depth = 9'(cnt_q);
        state_d = SIdle;
        done_d = 1'b1;
        case (op_q)
          OpMove, OpAdd, OpSub, OpNeg, OpAnd, OpOr, OpNot: begin
            rf_we = 1'b1;
            rsp_d.dest_value = res;
          end
          OpXchg: begin
            rf_we = 1'b1;
            rsp_d.dest_value = res;
            if (s_q != d_q) begin
              state_d = SWr2;
              done_d = 1'b0;
            end
          end
          OpPush: begin
            if (cnt_q >= CountW'(StackDepth)) begin
              rsp_d.status = StOverflow;
            end else begin
              st_we = 1'b1;
              cnt_d = cnt_q + CountW'(1);
              rsp_d.stack_depth = 9'(cnt_q + CountW'(1));
            end
          end
          OpPop: begin
            if (cnt_q == '0) begin
              rsp_d.status = StUnderflow;
            end else begin
              state_d = SPop;
              done_d = 1'b0;
            end
          end
          OpMul, OpDiv: begin
            if (op_q == OpDiv && sv == 0) begin
              rsp_d.status = StDivZero;
            end else begin
              md_start = 1'b1;
              state_d = SMd;
              done_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      SMd: begin
        if (md_done) begin
          rf_we = 1'b1;
          rf_wd = md_res;
          rsp_d.dest_value = md_res;
          done_d = 1'b1;
          state_d = SIdle;
        end
      end
      SPop: begin
        rf_we = 1'b1;
        rf_wd = st_rd;
        cnt_d = cnt_q - CountW'(1);
        rsp_d.dest_value = st_rd;
        rsp_d.stack_depth = 9'(cnt_q - CountW'(1));
        done_d = 1'b1;
        state_d = SIdle;
      end
      SWr2: begin
        rf_we = 1'b1;
        rf_wa = s_q;
        rf_wd = dv_q;
        done_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      clr_q <= '0;
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (accept) begin
      op_q <= req_i.opcode;
      d_q <= req_i.dest_index[RegIdxW-1:0];
      s_q <= req_i.src_operand[RegIdxW-1:0];
      imm_q <= req_i.src_operand;
    end
    if (state_q == SExec) begin
      dv_q <= dv;
    end
  end

  `RVM_ASSERT_IMP(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CountW'(StackDepth))
  `RVM_ASSERT_NEXT(a_accept_read, clk_i, rst_ni, accept, state_q == SRead)
  `RVM_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, state_q == SIdle)
endmodule
`default_nettype wire

[test/tb_register_vm_execute_unit_core.sv]
`timescale 1ns / 1ps
module tb_register_vm_execute_unit_core;
  import rvm_pkg::*;

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  rsp_t  rsp_o;

  register_vm_execute_unit_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  typedef struct {
    opcode_e         op;
    logic [3:0]      dst;
    logic [31:0]     src;
    bit              fixed;
    rsp_t            rsp;
  } row_t;

  logic [31:0] regs_m [NumRegs];
  logic [31:0] stack_m [StackDepth];
  int unsigned depth_m;
  rsp_t        pending_q[$];
  int          errors;
  int          issued;
  int          checked;
  int          idle_cycles;
  bit          no_gaps;
  int          op_hits [16];
  int          status_hits [4];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic rsp_t execute_instr(opcode_e op, logic [3:0] dst, logic [31:0] src);
    rsp_t        r;
    logic [3:0]  s;
    logic [31:0] dv;
    logic [31:0] sv;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    status_e     st;
    s  = src[3:0];
    dv = regs_m[dst];
    sv = regs_m[s];
    st = StOk;
    case (op)
      OpMove: regs_m[dst] = src;
      OpXchg: begin
        regs_m[dst] = sv;
        regs_m[s]   = dv;
      end
      OpPush: begin
        if (depth_m >= StackDepth) begin
          st = StOverflow;
        end else begin
          stack_m[depth_m] = dv;
          depth_m++;
        end
      end
      OpPop: begin
        if (depth_m == 0) begin
          st = StUnderflow;
        end else begin
          depth_m--;
          regs_m[dst] = stack_m[depth_m];
        end
      end
      OpAdd: regs_m[dst] = dv + sv;
      OpSub: regs_m[dst] = dv - sv;
      OpMul: regs_m[dst] = dv * sv;
      OpDiv: begin
        if (sv == 32'd0) begin
          st = StDivZero;
        end else begin
          ma = dv[31] ? -dv : dv;
          mb = sv[31] ? -sv : sv;
          q  = ma / mb;
          regs_m[dst] = (dv[31] != sv[31]) ? -q : q;
        end
      end
      OpNeg: regs_m[dst] = -dv;
      OpAnd: regs_m[dst] = {31'd0, (dv != 0) && (sv != 0)};
      OpOr:  regs_m[dst] = {31'd0, (dv != 0) || (sv != 0)};
      OpNot: regs_m[dst] = {31'd0, dv == 0};
      default: ;
    endcase
    r.status      = st;
    r.dest_value  = regs_m[dst];
    r.stack_depth = depth_m[8:0];
    return r;
  endfunction

  task automatic issue(opcode_e op, logic [3:0] dst, logic [31:0] src, bit fixed, rsp_t want);
    rsp_t pred;
    if (!no_gaps) begin
      while ($urandom_range(99) < 15) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i   <= '{opcode: op, dest_index: dst, src_operand: src};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pred = execute_instr(op, dst, src);
    if (fixed && pred != want) begin
      $display("%0t directed row disagrees: expected %h, predicted %h", $time, want, pred);
      errors++;
    end
    pending_q.push_back(fixed ? want : pred);
    op_hits[op]++;
    status_hits[pred.status]++;
    issued++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rsp_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t result with nothing expected: actual %h", $time, rsp_o);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (rsp_o.status !== exp_r.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, exp_r.status, rsp_o.status);
          errors++;
        end
        if (rsp_o.dest_value !== exp_r.dest_value) begin
          $display("%0t dest_value: expected %h, actual %h", $time, exp_r.dest_value,
                   rsp_o.dest_value);
          errors++;
        end
        if (rsp_o.stack_depth !== exp_r.stack_depth) begin
          $display("%0t stack_depth: expected %0d, actual %0d", $time, exp_r.stack_depth,
                   rsp_o.stack_depth);
          errors++;
        end
        checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic rsp_t mk(status_e st, logic [31:0] v, int unsigned d);
    rsp_t r;
    r.status = st;
    r.dest_value = v;
    r.stack_depth = d[8:0];
    return r;
  endfunction

  task automatic random_instr();
    opcode_e     op;
    logic [3:0]  dst;
    logic [31:0] src;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 12) begin
      op = OpMove;
    end else if (k < 20) begin
      op = OpPush;
    end else if (k < 28) begin
      op = OpPop;
    end else begin
      op = opcode_e'($urandom_range(15));
    end
    dst = $urandom_range(15);
    case ($urandom_range(4))
      0: src = 32'h8000_0000;
      1: src = 32'hFFFF_FFFF;
      2: src = $urandom_range(3);
      default: src = $urandom;
    endcase
    if (op == OpPop && depth_m == 0 && $urandom_range(3) != 0) op = OpPush;
    issue(op, dst, src, 1'b0, '0);
  endtask

  initial begin
    row_t rows[$];
    int   n;
    errors = 0;
    issued = 0;
    checked = 0;
    no_gaps = 1'b0;
    depth_m = 0;
    foreach (regs_m[i]) regs_m[i] = 32'd0;
    foreach (stack_m[i]) stack_m[i] = 32'd0;
    foreach (op_hits[i]) op_hits[i] = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    rows = '{
      '{OpNoop, 4'd0, 32'd0, 1'b1, mk(StOk, 32'd0, 0)},
      '{OpPop, 4'd3, 32'd0, 1'b1, mk(StUnderflow, 32'd0, 0)},
      '{OpMove, 4'd15, 32'h7FFF_FFFF, 1'b1, mk(StOk, 32'h7FFF_FFFF, 0)},
      '{OpMove, 4'd1, 32'h8000_0000, 1'b1, mk(StOk, 32'h8000_0000, 0)},
      '{OpMove, 4'd2, 32'hFFFF_FFFF, 1'b1, mk(StOk, 32'hFFFF_FFFF, 0)},
      '{OpDiv, 4'd1, 32'd2, 1'b1, mk(StOk, 32'h8000_0000, 0)},
      '{OpDiv, 4'd1, 32'd0, 1'b1, mk(StDivZero, 32'h8000_0000, 0)},
      '{OpDiv, 4'd15, 32'hFFFF_FFF2, 1'b0, '0},
      '{OpAdd, 4'd15, 32'd15, 1'b0, '0},
      '{OpSub, 4'd2, 32'd1, 1'b0, '0},
      '{OpMul, 4'd1, 32'd2, 1'b0, '0},
      '{OpNeg, 4'd1, 32'd0, 1'b0, '0},
      '{OpXchg, 4'd2, 32'hFFFF_FFF1, 1'b0, '0},
      '{OpXchg, 4'd4, 32'd4, 1'b0, '0},
      '{OpAnd, 4'd1, 32'd0, 1'b0, '0},
      '{OpOr, 4'd0, 32'd5, 1'b0, '0},
      '{OpNot, 4'd5, 32'd0, 1'b0, '0},
      '{OpPush, 4'd2, 32'd0, 1'b0, '0},
      '{OpPop, 4'd9, 32'd0, 1'b0, '0},
      '{OpRes13, 4'd0, 32'd0, 1'b0, '0},
      '{OpRes14, 4'd1, 32'd0, 1'b0, '0},
      '{OpRes15, 4'd2, 32'hFFFF_FFFF, 1'b0, '0}
    };
    foreach (rows[i]) issue(rows[i].op, rows[i].dst, rows[i].src, rows[i].fixed, rows[i].rsp);

    // Fill the stack to the top, overflow it, then drain it past empty.
    for (int i = 0; i < StackDepth + 1; i++) begin
      issue(OpPush, 4'($urandom_range(15)), 32'd0, 1'b0, '0);
    end
    no_gaps = 1'b1;
    for (int i = 0; i < StackDepth + 1; i++) begin
      issue(OpPop, 4'($urandom_range(15)), 32'd0, 1'b0, '0);
    end
    no_gaps = 1'b0;

    n = 0;
    while (n < 1300) begin
      no_gaps = (n >= 600 && n < 900);
      random_instr();
      n++;
    end
    start_i <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("Issued %0d instructions, checked %0d results.", issued, checked);
    $display("Overflow %0d, underflow %0d, divide by zero %0d cases.",
             status_hits[StOverflow], status_hits[StUnderflow], status_hits[StDivZero]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+rtl
rtl/rvm_pkg.sv
rtl/rvm_ram.sv
rtl/rvm_muldiv.sv
rtl/register_vm_execute_unit_core.sv
test/tb_register_vm_execute_unit_core.sv
